[hw/rtl/feedforward_gain_agc_defines.svh]
// Assertion macros shared by the feedforward gain AGC RTL.
`ifndef FEEDFORWARD_GAIN_AGC_DEFINES_SVH
`define FEEDFORWARD_GAIN_AGC_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define FGA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define FGA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fga_pkg.sv]
// Shared constants, register indexes and control types for the feedforward gain AGC.
`timescale 1ns / 1ps
`default_nettype none
package fga_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int GAIN_BITS     = 32;
  localparam int RATE_BITS     = 16;
  localparam int REF_BITS      = 15;
  localparam int CEIL_BITS     = 31;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_COMPLEX_MODE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOOP_RATE       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REFERENCE_LEVEL = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_CEILING    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_GAIN      = 3'd4;

  localparam logic [RATE_BITS-1:0] LOOP_RATE_RST       = 16'd7;
  localparam logic [REF_BITS-1:0]  REFERENCE_LEVEL_RST = 15'd32767;

  // Operand pair routed to the shared multiplier.
  typedef enum logic [2:0] {
    MS_XR  = 3'd0,
    MS_XI  = 3'd1,
    MS_AR  = 3'd2,
    MS_AI  = 3'd3,
    MS_ERR = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_yr;
    logic     load_yi;
    logic     load_acc;
    logic     load_rad;
    logic     root_step;
    logic     load_mag;
    logic     load_sum;
    logic     update;
  } fga_cmd_t;

  typedef struct packed {
    logic complex_mode;
    logic root_done;
    logic out_free;
  } fga_sts_t;

endpackage
`default_nettype wire

[hw/rtl/fga_if.sv]
// Stream interfaces for the AGC sample input and result output channels.
`timescale 1ns / 1ps
`default_nettype none
interface fga_in_if #(
  parameter int SAMPLE_BITS = fga_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_real;
  logic signed [SAMPLE_BITS-1:0] in_imag;
  logic                          last_in;

  modport source (output valid, output in_real, output in_imag, output last_in, input ready);
  modport sink   (input valid, input in_real, input in_imag, input last_in, output ready);
endinterface

interface fga_out_if #(
  parameter int SAMPLE_BITS = fga_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_real;
  logic signed [SAMPLE_BITS-1:0] out_imag;
  logic                          last_out;

  modport source (output valid, output out_real, output out_imag, output last_out, input ready);
  modport sink   (input valid, input out_real, input out_imag, input last_out, output ready);
endinterface
`default_nettype wire

[hw/rtl/feedforward_gain_agc.sv]
// Top level of the feedforward gain AGC: controller, datapath and assertions.
//
//   Channel    | Direction | Payload                         | Handshake
//   -----------+-----------+---------------------------------+-------------------
//   sample_ch  | in        | in_real, in_imag, last_in       | valid / ready
//   result_ch  | out       | out_real, out_imag, last_out    | valid / ready
//   cfg        | in        | cfg_index, cfg_wdata            | cfg_we, no wait
//
// In complex mode an item also passes through the bit-per-cycle square root between its
// acceptance and the next acceptance; real mode skips the root and takes |yr| as the magnitude.
// The single shared multiplier serves the gain products, the two squares and the loop error.
// rst is synchronous and active high; it restores the state, configuration, gain and output valid registers.
// A result waits in the output register without blocking the next input item; only the
// final gain update stalls while the output register is still occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "feedforward_gain_agc_defines.svh"
module feedforward_gain_agc #(
  parameter int SAMPLE_BITS    = fga_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = fga_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fga_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fga_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  fga_in_if.sink                            sample_ch,
  fga_out_if.source                         result_ch
);
  import fga_pkg::*;

  // Commands flow from the controller to the datapath, status flows back.
  fga_cmd_t cmd;
  fga_sts_t sts;

  // The controller holds ready high only while idle, so exactly one item is in flight
  // inside the loop at a time; the gain it leaves is the gain the next item sees.
  fga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .in_ready (sample_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the configuration registers, the gain state and the output
  // register that decouples the result channel from the loop.
  fga_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_real   (sample_ch.in_real),
    .in_imag   (sample_ch.in_imag),
    .last_in   (sample_ch.last_in),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_real  (result_ch.out_real),
    .out_imag  (result_ch.out_imag),
    .last_out  (result_ch.last_out),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The gain update never overwrites a result that has not been taken.
  `FGA_ASSERT_IMPL(a_update_slot_free, cmd.update, sts.out_free, "update into a full output register")
  // Once an item is taken the loop is busy until its gain update is done.
  `FGA_ASSERT_NEXT(a_single_item, sample_ch.valid && sample_ch.ready, !sample_ch.ready, "second item accepted while busy")
  // Every update presents a result on the next cycle.
  `FGA_ASSERT_NEXT(a_update_shows_result, cmd.update, result_ch.valid, "update did not present a result")
  // A square root step is only issued in complex mode.
  `FGA_ASSERT_IMPL(a_root_complex_only, cmd.root_step, sts.complex_mode, "square root step in real mode")

endmodule
`default_nettype wire

[hw/rtl/fga_ctrl.sv]
// Sequencing state machine for the AGC: steps one item through the shared datapath.
`timescale 1ns / 1ps
`default_nettype none
module fga_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fga_pkg::fga_sts_t sts,
  output fga_pkg::fga_cmd_t cmd
);
  import fga_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_MUL_R = 11'b000_0000_0010,
    ST_MUL_I = 11'b000_0000_0100,
    ST_SAT_I = 11'b000_0000_1000,
    ST_SQ_I  = 11'b000_0001_0000,
    ST_SUM   = 11'b000_0010_0000,
    ST_ROOT  = 11'b000_0100_0000,
    ST_REAL  = 11'b000_1000_0000,
    ST_ERR   = 11'b001_0000_0000,
    ST_ADD   = 11'b010_0000_0000,
    ST_UPD   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mul_sel = MS_XR;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = ST_MUL_R;
        end
      end
      ST_MUL_R: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_XR;
        state_next  = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.load_yr = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_XI;
        state_next  = sts.complex_mode ? ST_SAT_I : ST_REAL;
      end
      ST_SAT_I: begin
        cmd.load_yi = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_AR;
        state_next  = ST_SQ_I;
      end
      ST_SQ_I: begin
        cmd.load_acc = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_AI;
        state_next   = ST_SUM;
      end
      ST_SUM: begin
        cmd.load_rad = 1'b1;
        state_next   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_done) begin
          state_next = ST_ERR;
        end
      end
      ST_REAL: begin
        cmd.load_mag = 1'b1;
        state_next   = ST_ERR;
      end
      ST_ERR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_ERR;
        state_next  = ST_ADD;
      end
      ST_ADD: begin
        cmd.load_sum = 1'b1;
        state_next   = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = sts.out_free;
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/fga_datapath.sv]
// AGC datapath: config registers, gain state, shared multiplier, square root and output register.
`timescale 1ns / 1ps
`default_nettype none
module fga_datapath #(
  parameter int SAMPLE_BITS    = fga_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = fga_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fga_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [fga_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]      in_real,
  input  logic signed [SAMPLE_BITS-1:0]      in_imag,
  input  logic                               last_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_real,
  output logic signed [SAMPLE_BITS-1:0]      out_imag,
  output logic                               last_out,
  input  fga_pkg::fga_cmd_t                  cmd,
  output fga_pkg::fga_sts_t                  sts
);
  import fga_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int F  = GAIN_FRAC_BITS;
  localparam int WA = ((S > 16) ? S : 16) + 2;
  localparam int WB = GAIN_BITS + 1;
  localparam int PW = WA + WB;
  localparam int DW = PW + 2;
  localparam int K  = 15 + S - F;
  localparam int KP = (K > 0) ? K : 0;
  localparam int KN = (K < 0) ? -K : 0;
  localparam int KR = (K > 0) ? K - 1 : 0;
  localparam int CW = $clog2(S);

  localparam logic signed [PW-1:0] RND_F = {{(PW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic signed [PW-1:0] SMAX  = {{(PW-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN  = ~SMAX;
  localparam logic signed [DW-1:0] RND_K = (K > 0) ? ({{(DW-1){1'b0}}, 1'b1} << KR) : '0;
  localparam logic signed [DW-1:0] GMAX  = {{(DW-GAIN_BITS+1){1'b0}}, {(GAIN_BITS-1){1'b1}}};
  localparam logic signed [DW-1:0] GMIN  = ~GMAX;
  localparam logic [GAIN_BITS-1:0] GAIN_RST = {{(GAIN_BITS-1){1'b0}}, 1'b1} << F;

  // Round-half-up, floor shift by F, saturate to a sample.
  function automatic logic signed [S-1:0] scale_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] q;
    r = p + RND_F;
    q = r >>> F;
    if (q > SMAX) begin
      return SMAX[S-1:0];
    end else if (q < SMIN) begin
      return SMIN[S-1:0];
    end
    return q[S-1:0];
  endfunction

  function automatic logic [S-1:0] abs_s(input logic signed [S-1:0] v);
    return v[S-1] ? S'(-v) : S'(v);
  endfunction

  // Configuration registers and loop state.
  logic                        complex_mode;
  logic [RATE_BITS-1:0]        loop_rate;
  logic [REF_BITS-1:0]         reference_level;
  logic [CEIL_BITS-1:0]        gain_ceiling;
  logic signed [GAIN_BITS-1:0] gain;

  // Item registers.
  logic signed [S-1:0]  xr;
  logic signed [S-1:0]  xi;
  logic                 last_r;
  logic signed [PW-1:0] prod;
  logic signed [S-1:0]  yr;
  logic signed [S-1:0]  yi;
  logic [2*S-1:0]       acc;
  logic [2*S-1:0]       rad;
  logic [S+1:0]         rem;
  logic [S-1:0]         root;
  logic [S-1:0]         mag;
  logic [CW-1:0]        cnt;
  logic signed [DW-1:0] sum;

  logic signed [WA-1:0] a_op;
  logic signed [WB-1:0] b_op;
  logic signed [WA-1:0] ref_ext;
  logic signed [WA-1:0] mag_ext;
  logic [S-1:0]         abs_r;
  logic [S-1:0]         abs_i;

  logic [S+1:0]         rem_sh;
  logic [S+1:0]         trial;
  logic                 take;
  logic [S+1:0]         rem_next;
  logic [S-1:0]         root_next;

  logic signed [DW-1:0]        prod_ext;
  logic signed [DW-1:0]        delta;
  logic signed [DW-1:0]        gain_ext;
  logic signed [GAIN_BITS-1:0] gain_sat;
  logic signed [GAIN_BITS-1:0] ceil_s;
  logic signed [GAIN_BITS-1:0] gain_next;

  assign abs_r   = abs_s(yr);
  assign abs_i   = abs_s(yi);
  assign ref_ext = {{(WA-REF_BITS){1'b0}}, reference_level};
  assign mag_ext = {{(WA-S){1'b0}}, mag};

  always_comb begin
    a_op = {{(WA-S){xr[S-1]}}, xr};
    b_op = {gain[GAIN_BITS-1], gain};
    unique case (cmd.mul_sel)
      MS_XR: begin
        a_op = {{(WA-S){xr[S-1]}}, xr};
        b_op = {gain[GAIN_BITS-1], gain};
      end
      MS_XI: begin
        a_op = {{(WA-S){xi[S-1]}}, xi};
        b_op = {gain[GAIN_BITS-1], gain};
      end
      MS_AR: begin
        a_op = {{(WA-S){1'b0}}, abs_r};
        b_op = {{(WB-S){1'b0}}, abs_r};
      end
      MS_AI: begin
        a_op = {{(WA-S){1'b0}}, abs_i};
        b_op = {{(WB-S){1'b0}}, abs_i};
      end
      MS_ERR: begin
        a_op = ref_ext - mag_ext;
        b_op = {{(WB-RATE_BITS){1'b0}}, loop_rate};
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  // One result bit per step of the digit-by-digit square root.
  assign rem_sh    = {rem[S-1:0], rad[2*S-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign take      = (rem_sh >= trial);
  assign rem_next  = take ? (rem_sh - trial) : rem_sh;
  assign root_next = {root[S-2:0], take};

  assign prod_ext = {{2{prod[PW-1]}}, prod};
  assign delta    = ((prod_ext + RND_K) >>> KP) <<< KN;
  assign gain_ext = {{(DW-GAIN_BITS){gain[GAIN_BITS-1]}}, gain};
  assign ceil_s   = {1'b0, gain_ceiling};

  always_comb begin
    if (sum > GMAX) begin
      gain_sat = GMAX[GAIN_BITS-1:0];
    end else if (sum < GMIN) begin
      gain_sat = GMIN[GAIN_BITS-1:0];
    end else begin
      gain_sat = sum[GAIN_BITS-1:0];
    end
    if ((gain_ceiling != '0) && (gain_sat > ceil_s)) begin
      gain_next = ceil_s;
    end else begin
      gain_next = gain_sat;
    end
  end

  // Configuration writes and the gain state.
  always_ff @(posedge clk) begin
    if (rst) begin
      complex_mode    <= 1'b1;
      loop_rate       <= LOOP_RATE_RST;
      reference_level <= REFERENCE_LEVEL_RST;
      gain_ceiling    <= '0;
      gain            <= GAIN_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COMPLEX_MODE:    complex_mode    <= cfg_wdata[0];
          REG_LOOP_RATE:       loop_rate       <= cfg_wdata[RATE_BITS-1:0];
          REG_REFERENCE_LEVEL: reference_level <= cfg_wdata[REF_BITS-1:0];
          REG_GAIN_CEILING:    gain_ceiling    <= cfg_wdata[CEIL_BITS-1:0];
          REG_START_GAIN:      gain            <= cfg_wdata[GAIN_BITS-1:0];
          default: begin
          end
        endcase
      end else if (cmd.update) begin
        gain <= gain_next;
      end
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      xr     <= in_real;
      xi     <= in_imag;
      last_r <= last_in;
    end
    if (cmd.mul_en) begin
      prod <= a_op * b_op;
    end
    if (cmd.load_yr) begin
      yr <= scale_sat(prod);
    end
    if (cmd.load_yi) begin
      yi <= scale_sat(prod);
    end
    if (cmd.load_acc) begin
      acc <= prod[2*S-1:0];
    end
    if (cmd.load_rad) begin
      rad  <= acc + prod[2*S-1:0];
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (cmd.root_step) begin
      rad  <= rad << 2;
      rem  <= rem_next;
      root <= root_next;
      cnt  <= cnt + 1'b1;
      if (sts.root_done) begin
        mag <= root_next;
      end
    end
    if (cmd.load_mag) begin
      mag <= abs_r;
    end
    if (cmd.load_sum) begin
      sum <= gain_ext + delta;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_real <= yr;
      out_imag <= complex_mode ? yi : '0;
      last_out <= last_r;
    end
  end

  assign sts.complex_mode = complex_mode;
  assign sts.root_done    = (cnt == CW'(S - 1));
  assign sts.out_free     = !out_valid || out_ready;

endmodule
`default_nettype wire
